### sv/link_frame_receiver_unit_macros.svh
// assertion macros for the link frame receiver
// used by link_frame_receiver_unit.sv; relies on clk and rst_n in the including scope
`ifndef LINK_FRAME_RECEIVER_UNIT_MACROS_SVH
`define LINK_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LFR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lfr_pkg.sv
// shared types and constants of the link frame receiver
// no dependencies; used by link_frame_receiver_unit.sv
package lfr_pkg;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_ADDR    = 4'd1,
    PH_CMD     = 4'd2,
    PH_HCHK    = 4'd3,
    PH_CTLFLAG = 4'd4,
    PH_NEEDBUF = 4'd5,
    PH_DATA    = 4'd6,
    PH_ESC     = 4'd7,
    PH_DONE    = 4'd8,
    PH_CLOSED  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_UNFIN   = 3'd0,
    ST_OK      = 3'd1,
    ST_REJ     = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_NEEDBUF = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_GRANT = 2'd1,
    OP_OPEN  = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_FLAG   = 2'd0,
    CFG_ESCAPE = 2'd1,
    CFG_ADDR_A = 2'd2,
    CFG_ADDR_B = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] STUFF_XOR = 8'h20;

  localparam logic [7:0] CMD_I_A = 8'h00;
  localparam logic [7:0] CMD_I_B = 8'h40;

  localparam logic [7:0] FLAG_RST   = 8'h7E;
  localparam logic [7:0] ESCAPE_RST = 8'h7D;
  localparam logic [7:0] ADDR_A_RST = 8'h03;
  localparam logic [7:0] ADDR_B_RST = 8'h01;

  // command byte is one of the supported link commands
  function automatic logic cmd_known(input logic [7:0] c);
    case (c)
      8'h03, 8'h07, 8'h05, 8'h85, 8'h01, 8'h81, 8'h0B, CMD_I_A, CMD_I_B: cmd_known = 1'b1;
      default: cmd_known = 1'b0;
    endcase
  endfunction

endpackage

### sv/link_frame_receiver_unit.sv
// link frame receiver: flag/address/command/header check, destuffed payload, frame check
// depends on lfr_pkg.sv and link_frame_receiver_unit_macros.svh
//
// channel | dir | handshake          | contents
// in_     | in  | in_tvalid/tready   | tuser: op, tdata: rx_byte, buffer_capacity
// out_    | out | out_tvalid/tready  | tuser: status, tdata: frame and write fields
// cfg_    | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// one event per cycle: each accepted transfer is decoded in a single pass against the
// frame state and its result lands in the output register on the same edge
// one result per event, so the output register alone sets the rate; it reloads in the
// cycle it is taken, and in_tready falls only while a result waits on a stalled out_tready
// synchronous active-low reset: link closed, frame state cleared, registers at defaults
`include "link_frame_receiver_unit_macros.svh"

module link_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic [23:0] in_tdata,   // [7:0] rx_byte, [23:8] buffer_capacity
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic [63:0] out_tdata,  // [7:0] frame_address, [15:8] frame_command,
                                  // [16] write_valid, [32:17] write_index,
                                  // [40:33] write_data, [56:41] payload_length, rest zero
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  // configuration registers
  logic [7:0] flag_r, escape_r, addr_a_r, addr_b_r;

  // frame state
  lfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  accum_r, accum_nxt;
  logic [7:0]  held_addr_r, held_addr_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic        link_open_r, link_open_nxt;

  // output register
  logic        out_tvalid_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_data_r;

  // decoded input transfer
  logic            in_fire;
  lfr_pkg::op_t    in_op;
  logic [7:0]      rx_byte;
  logic [15:0]     rx_cap;

  // result of this event
  lfr_pkg::status_t res_status;
  logic        res_wv;
  logic [15:0] res_widx;
  logic [7:0]  res_wdata;
  logic [15:0] res_plen;

  logic       is_flag;
  logic [7:0] hchk_accum;
  logic [7:0] esc_data;

  assign in_tready = !out_tvalid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_op     = lfr_pkg::op_t'(in_tuser);
  assign rx_byte   = in_tdata[7:0];
  assign rx_cap    = in_tdata[23:8];

  assign is_flag    = (rx_byte == flag_r);
  assign hchk_accum = accum_r ^ rx_byte;
  assign esc_data   = rx_byte ^ lfr_pkg::STUFF_XOR;

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= lfr_pkg::FLAG_RST;
      escape_r <= lfr_pkg::ESCAPE_RST;
      addr_a_r <= lfr_pkg::ADDR_A_RST;
      addr_b_r <= lfr_pkg::ADDR_B_RST;
    end else if (cfg_we) begin
      unique case (lfr_pkg::cfg_idx_t'(cfg_addr))
        lfr_pkg::CFG_FLAG:   flag_r   <= cfg_wdata;
        lfr_pkg::CFG_ESCAPE: escape_r <= cfg_wdata;
        lfr_pkg::CFG_ADDR_A: addr_a_r <= cfg_wdata;
        lfr_pkg::CFG_ADDR_B: addr_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next frame state and result of one event
  always_comb begin
    phase_nxt     = phase_r;
    accum_nxt     = accum_r;
    held_addr_nxt = held_addr_r;
    held_cmd_nxt  = held_cmd_r;
    bytes_nxt     = bytes_r;
    cap_nxt       = cap_r;
    link_open_nxt = link_open_r;
    res_status    = lfr_pkg::ST_UNFIN;
    res_wv        = 1'b0;
    res_widx      = '0;
    res_wdata     = '0;
    res_plen      = '0;

    if (in_fire) begin
      unique case (in_op)
        lfr_pkg::OP_OPEN: begin
          link_open_nxt = 1'b1;
          phase_nxt     = lfr_pkg::PH_START;
          accum_nxt     = '0;
          held_addr_nxt = '0;
          held_cmd_nxt  = '0;
          bytes_nxt     = '0;
          cap_nxt       = '0;
        end
        lfr_pkg::OP_CLOSE: begin
          link_open_nxt = 1'b0;
          phase_nxt     = lfr_pkg::PH_CLOSED;
          accum_nxt     = '0;
          held_addr_nxt = '0;
          held_cmd_nxt  = '0;
          bytes_nxt     = '0;
          cap_nxt       = '0;
          res_status    = lfr_pkg::ST_CLOSED;
        end
        lfr_pkg::OP_GRANT: begin
          // grant only counts while a buffer is awaited
          if (phase_r == lfr_pkg::PH_NEEDBUF && link_open_r) begin
            cap_nxt   = rx_cap;
            bytes_nxt = '0;
            phase_nxt = lfr_pkg::PH_DATA;
          end
        end
        lfr_pkg::OP_BYTE: begin
          if (!link_open_r || phase_r == lfr_pkg::PH_CLOSED) begin
            phase_nxt  = lfr_pkg::PH_CLOSED;
            res_status = lfr_pkg::ST_CLOSED;
          end else begin
            // after a good frame, drop its fields and hunt again
            if (phase_r == lfr_pkg::PH_DONE) begin
              held_addr_nxt = '0;
              held_cmd_nxt  = '0;
              bytes_nxt     = '0;
              cap_nxt       = '0;
              phase_nxt     = lfr_pkg::PH_START;
            end
            unique case (phase_nxt)
              lfr_pkg::PH_START: begin
                if (is_flag) phase_nxt = lfr_pkg::PH_ADDR;
              end
              lfr_pkg::PH_ADDR: begin
                // a repeated flag keeps waiting for the address
                if (!is_flag) begin
                  if (rx_byte == addr_a_r || rx_byte == addr_b_r) begin
                    held_addr_nxt = rx_byte;
                    accum_nxt     = accum_r ^ rx_byte;
                    phase_nxt     = lfr_pkg::PH_CMD;
                  end else begin
                    phase_nxt = lfr_pkg::PH_START;
                  end
                end
              end
              lfr_pkg::PH_CMD: begin
                if (lfr_pkg::cmd_known(rx_byte)) begin
                  held_cmd_nxt = rx_byte;
                  accum_nxt    = accum_r ^ rx_byte;
                  phase_nxt    = lfr_pkg::PH_HCHK;
                end else begin
                  held_cmd_nxt = '0;
                  accum_nxt    = '0;
                  phase_nxt    = is_flag ? lfr_pkg::PH_ADDR : lfr_pkg::PH_START;
                end
              end
              lfr_pkg::PH_HCHK: begin
                accum_nxt = '0;
                if (hchk_accum != 8'd0) begin
                  phase_nxt = is_flag ? lfr_pkg::PH_ADDR : lfr_pkg::PH_START;
                end else if (held_cmd_r == lfr_pkg::CMD_I_A ||
                             held_cmd_r == lfr_pkg::CMD_I_B) begin
                  phase_nxt  = lfr_pkg::PH_NEEDBUF;
                  res_status = lfr_pkg::ST_NEEDBUF;
                end else begin
                  phase_nxt = lfr_pkg::PH_CTLFLAG;
                end
              end
              lfr_pkg::PH_CTLFLAG: begin
                if (is_flag) begin
                  phase_nxt  = lfr_pkg::PH_DONE;
                  res_status = lfr_pkg::ST_OK;
                end else begin
                  phase_nxt = lfr_pkg::PH_START;
                end
              end
              lfr_pkg::PH_NEEDBUF: begin
                res_status = lfr_pkg::ST_NEEDBUF;
              end
              lfr_pkg::PH_DATA: begin
                if (is_flag) begin
                  // closing flag: check byte included, so accumulator must be zero
                  if (accum_r == 8'd0 && bytes_r != 16'd0) begin
                    bytes_nxt  = bytes_r - 16'd1;
                    res_plen   = bytes_r - 16'd1;
                    phase_nxt  = lfr_pkg::PH_DONE;
                    res_status = lfr_pkg::ST_OK;
                  end else begin
                    accum_nxt  = '0;
                    bytes_nxt  = '0;
                    phase_nxt  = lfr_pkg::PH_ADDR;
                    res_status = lfr_pkg::ST_REJ;
                  end
                end else if (bytes_r >= cap_r) begin
                  // buffer full
                  accum_nxt  = '0;
                  bytes_nxt  = '0;
                  phase_nxt  = lfr_pkg::PH_START;
                  res_status = lfr_pkg::ST_REJ;
                end else if (rx_byte == escape_r) begin
                  phase_nxt = lfr_pkg::PH_ESC;
                end else begin
                  accum_nxt = accum_r ^ rx_byte;
                  res_wv    = 1'b1;
                  res_widx  = bytes_r;
                  res_wdata = rx_byte;
                  bytes_nxt = bytes_r + 16'd1;
                end
              end
              lfr_pkg::PH_ESC: begin
                // stuffed byte, flag value included
                accum_nxt = accum_r ^ esc_data;
                res_wv    = 1'b1;
                res_widx  = bytes_r;
                res_wdata = esc_data;
                bytes_nxt = bytes_r + 16'd1;
                phase_nxt = lfr_pkg::PH_DATA;
              end
              default: phase_nxt = lfr_pkg::PH_START;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lfr_pkg::PH_CLOSED;
      accum_r     <= '0;
      held_addr_r <= '0;
      held_cmd_r  <= '0;
      bytes_r     <= '0;
      cap_r       <= '0;
      link_open_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
      held_addr_r <= held_addr_nxt;
      held_cmd_r  <= held_cmd_nxt;
      bytes_r     <= bytes_nxt;
      cap_r       <= cap_nxt;
      link_open_r <= link_open_nxt;
    end
  end

  // output register: valid under reset, payload loads on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_tready) begin
      out_tvalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= res_status;
      out_data_r   <= {7'd0, res_plen, res_wdata, res_widx, res_wv, held_cmd_nxt, held_addr_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

  // checks
  `LFR_ASSERT_SAME(a_closed_phase, !link_open_r, phase_r == lfr_pkg::PH_CLOSED, "closed link left the closed phase")
  `LFR_ASSERT_SAME(a_fill_bound, phase_r == lfr_pkg::PH_DATA || phase_r == lfr_pkg::PH_ESC, bytes_r <= cap_r, "payload count beyond granted capacity")
  `LFR_ASSERT_SAME(a_write_status, out_tvalid_r && out_data_r[16], out_status_r == lfr_pkg::ST_UNFIN, "payload write with a final status")
  `LFR_ASSERT_NEXT(a_esc_writes, in_fire && in_op == lfr_pkg::OP_BYTE && phase_r == lfr_pkg::PH_ESC && link_open_r, out_tvalid_r && out_data_r[16], "escaped byte not written")

endmodule

### dv/lfr_checker.sv
// checker for the link frame receiver: command table shared with the bench, frame predictor,
// result comparison; depends on lfr_pkg.sv from the rtl
`timescale 1ns / 100ps

package lfr_tb_pkg;
  import lfr_pkg::*;

  localparam logic [7:0] CMD_SET  = 8'h03;
  localparam logic [7:0] CMD_UA   = 8'h07;
  localparam logic [7:0] CMD_RR0  = 8'h05;
  localparam logic [7:0] CMD_RR1  = 8'h85;
  localparam logic [7:0] CMD_REJ0 = 8'h01;
  localparam logic [7:0] CMD_REJ1 = 8'h81;
  localparam logic [7:0] CMD_DISC = 8'h0B;

  // supervision commands come first, the two information commands last
  localparam int N_SUP_CMDS  = 7;
  localparam int N_LINK_CMDS = 9;

  function automatic logic [7:0] link_cmd(input int k);
    case (k)
      0: return CMD_SET;
      1: return CMD_UA;
      2: return CMD_RR0;
      3: return CMD_RR1;
      4: return CMD_REJ0;
      5: return CMD_REJ1;
      6: return CMD_DISC;
      7: return CMD_I_A;
      default: return CMD_I_B;
    endcase
  endfunction

  function automatic bit is_link_cmd(input logic [7:0] c);
    for (int k = 0; k < N_LINK_CMDS; k++) begin
      if (link_cmd(k) == c) return 1'b1;
    end
    return 1'b0;
  endfunction
endpackage

module lfr_checker
  import lfr_pkg::*;
  import lfr_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [2:0]  out_tuser,
  input  logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    status_t     status;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic        wr_valid;
    logic [15:0] wr_index;
    logic [7:0]  wr_data;
    logic [15:0] plen;
  } rx_result_t;

  rx_result_t results_due[$];
  int errors = 0;

  logic [7:0] flag_v, esc_v, addr_a_v, addr_b_v;
  phase_t     ph;
  logic [7:0] acc, h_addr, h_cmd;
  logic [15:0] nwritten, cap_granted;
  logic       open_link;

  task automatic drop_frame();
    acc = '0;
    h_addr = '0;
    h_cmd = '0;
    nwritten = '0;
    cap_granted = '0;
  endtask

  task automatic store_payload(input logic [7:0] v, inout rx_result_t r);
    acc ^= v;
    r.wr_valid = 1'b1;
    r.wr_index = nwritten;
    r.wr_data = v;
    nwritten = nwritten + 16'd1;
  endtask

  task automatic advance_frame(input op_t op, input logic [7:0] b, input logic [15:0] cap,
                               output rx_result_t r);
    r = '0;
    r.status = ST_UNFIN;
    case (op)
      OP_OPEN: begin
        open_link = 1'b1;
        ph = PH_START;
        drop_frame();
      end
      OP_CLOSE: begin
        open_link = 1'b0;
        ph = PH_CLOSED;
        drop_frame();
        r.status = ST_CLOSED;
      end
      OP_GRANT: begin
        if (ph == PH_NEEDBUF && open_link) begin
          cap_granted = cap;
          nwritten = '0;
          ph = PH_DATA;
        end
      end
      default: begin
        if (!open_link || ph == PH_CLOSED) begin
          ph = PH_CLOSED;
          r.status = ST_CLOSED;
        end else begin
          // a byte after a good frame starts a fresh hunt
          if (ph == PH_DONE) begin
            h_addr = '0;
            h_cmd = '0;
            nwritten = '0;
            cap_granted = '0;
            ph = PH_START;
          end
          case (ph)
            PH_START: if (b == flag_v) ph = PH_ADDR;
            PH_ADDR: begin
              if (b != flag_v) begin
                if (b == addr_a_v || b == addr_b_v) begin
                  h_addr = b;
                  acc ^= b;
                  ph = PH_CMD;
                end else begin
                  ph = PH_START;
                end
              end
            end
            PH_CMD: begin
              h_cmd = b;
              acc ^= b;
              if (is_link_cmd(b)) begin
                ph = PH_HCHK;
              end else begin
                h_cmd = '0;
                acc = '0;
                ph = (b == flag_v) ? PH_ADDR : PH_START;
              end
            end
            PH_HCHK: begin
              acc ^= b;
              if (acc != 8'h00) begin
                acc = '0;
                ph = (b == flag_v) ? PH_ADDR : PH_START;
              end else if (h_cmd == CMD_I_A || h_cmd == CMD_I_B) begin
                ph = PH_NEEDBUF;
                r.status = ST_NEEDBUF;
              end else begin
                ph = PH_CTLFLAG;
              end
            end
            PH_CTLFLAG: begin
              if (b == flag_v) begin
                ph = PH_DONE;
                r.status = ST_OK;
              end else begin
                ph = PH_START;
              end
            end
            PH_NEEDBUF: r.status = ST_NEEDBUF;
            PH_DATA: begin
              if (b == flag_v) begin
                if (acc == 8'h00 && nwritten != 16'd0) begin
                  nwritten = nwritten - 16'd1;
                  r.plen = nwritten;
                  ph = PH_DONE;
                  r.status = ST_OK;
                end else begin
                  acc = '0;
                  nwritten = '0;
                  ph = PH_ADDR;
                  r.status = ST_REJ;
                end
              end else if (nwritten >= cap_granted) begin
                acc = '0;
                nwritten = '0;
                ph = PH_START;
                r.status = ST_REJ;
              end else if (b == esc_v) begin
                ph = PH_ESC;
              end else begin
                store_payload(b, r);
              end
            end
            PH_ESC: begin
              store_payload(b ^ STUFF_XOR, r);
              ph = PH_DATA;
            end
            default: ph = PH_START;
          endcase
        end
      end
    endcase
    r.addr = h_addr;
    r.cmd = h_cmd;
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rx_result_t want, fresh;
    if (!rst_n) begin
      flag_v = FLAG_RST;
      esc_v = ESCAPE_RST;
      addr_a_v = ADDR_A_RST;
      addr_b_v = ADDR_B_RST;
      ph = PH_CLOSED;
      open_link = 1'b0;
      drop_frame();
      results_due.delete();
      pending_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual tuser 0x%0h tdata 0x%0h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = results_due.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("frame_address", want.addr, out_tdata[7:0]);
          check_field("frame_command", want.cmd, out_tdata[15:8]);
          check_field("write_valid", want.wr_valid, out_tdata[16]);
          check_field("write_index", want.wr_index, out_tdata[32:17]);
          check_field("write_data", want.wr_data, out_tdata[40:33]);
          check_field("payload_length", want.plen, out_tdata[56:41]);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_FLAG:   flag_v = cfg_wdata;
          CFG_ESCAPE: esc_v = cfg_wdata;
          CFG_ADDR_A: addr_a_v = cfg_wdata;
          default:    addr_b_v = cfg_wdata;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_frame(op_t'(in_tuser), in_tdata[7:0], in_tdata[23:8], fresh);
        results_due.push_back(fresh);
      end
      pending_count <= results_due.size();
    end
    fail_count <= errors;
  end

endmodule

### dv/tb_top.sv
// top of the link frame receiver bench: clock, reset, event stimulus and the verdict
// depends on lfr_pkg.sv, link_frame_receiver_unit.sv and lfr_checker.sv
`timescale 1ns / 100ps

module tb_top;
  import lfr_pkg::*;
  import lfr_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_EVENTS = 80;

  // how a generated frame is spoiled, if at all
  typedef enum int {
    FL_NONE     = 0,
    FL_HCHK     = 1,
    FL_CMD      = 2,
    FL_CHECK    = 3,
    FL_EMPTY    = 4,
    FL_OVERFLOW = 5,
    FL_CUT      = 6
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = OP_BYTE;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;
  logic [63:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_FLAG;
  logic [7:0]  cfg_wdata = '0;

  int n_fail;
  int n_due;
  int cycles = 0;
  int accepted = 0;
  bit quiet = 1'b0;
  bit link_up = 1'b0;

  // the bench's view of the register file, used to build frames
  logic [7:0] r_flag = FLAG_RST;
  logic [7:0] r_esc = ESCAPE_RST;
  logic [7:0] r_addr_a = ADDR_A_RST;
  logic [7:0] r_addr_b = ADDR_B_RST;

  always #10 clk = ~clk;

  link_frame_receiver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  lfr_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tuser      (in_tuser),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tuser     (out_tuser),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (n_fail),
    .pending_count (n_due)
  );

  // result side: stalls with a probability of about 15 percent, never while quiet
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 15);
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one event on the input channel; returns right after its transfer edge with
  // tvalid still high, so back-to-back events never toggle it within a step
  task automatic offer_event(input op_t op, input logic [7:0] b, input logic [15:0] cap,
                             input bit counted);
    if (!quiet) begin
      while ($urandom_range(99) < 15) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {cap, b};
    do @(posedge clk); while (!in_tready);
    if (counted) accepted++;
    if (op == OP_OPEN) link_up = 1'b1;
    if (op == OP_CLOSE) link_up = 1'b0;
  endtask

  // bytes on a closed link get a closed status from the block and are not counted
  task automatic send_byte(input logic [7:0] b);
    offer_event(OP_BYTE, b, 16'($urandom), link_up);
  endtask

  // payload byte with stuffing of flag and escape values
  task automatic send_stuffed(input logic [7:0] v);
    if (v == r_flag || v == r_esc) begin
      send_byte(r_esc);
      send_byte(v ^ STUFF_XOR);
    end else begin
      send_byte(v);
    end
  endtask

  // hold off the sender until every outstanding result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_due != 0) @(posedge clk);
  endtask

  // register writes on consecutive edges; only called with nothing in flight
  task automatic set_link_regs(input logic [7:0] f, input logic [7:0] e,
                               input logic [7:0] a, input logic [7:0] b);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_FLAG;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_addr <= CFG_ESCAPE;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_addr <= CFG_ADDR_A;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_addr <= CFG_ADDR_B;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    r_flag = f;
    r_esc = e;
    r_addr_a = a;
    r_addr_b = b;
  endtask

  // whole frame with random content, optionally spoiled in one way
  task automatic send_frame(input flaw_t flaw);
    logic [7:0]  addr, cmd, hchk, sum, v;
    logic [15:0] cap;
    int          n, pick;
    bit          info;
    addr = $urandom_range(1) ? r_addr_a : r_addr_b;
    info = (flaw == FL_CHECK || flaw == FL_EMPTY || flaw == FL_OVERFLOW) ||
           ($urandom_range(99) < 60);
    if (flaw == FL_CMD) begin
      do cmd = 8'($urandom); while (is_link_cmd(cmd));
    end else if (info) begin
      cmd = $urandom_range(1) ? CMD_I_A : CMD_I_B;
    end else begin
      cmd = link_cmd($urandom_range(N_SUP_CMDS - 1));
    end
    send_byte(r_flag);
    if ($urandom_range(9) == 0) send_byte(r_flag);  // repeated opening flag
    send_byte(addr);
    send_byte(cmd);
    if (flaw == FL_CMD) return;
    hchk = addr ^ cmd;
    if (flaw == FL_HCHK) hchk ^= 8'($urandom_range(1, 255));
    send_byte(hchk);
    if (flaw == FL_HCHK) return;
    if (!info) begin
      send_byte((flaw == FL_CUT) ? 8'($urandom) : r_flag);
      return;
    end
    // stray byte while the receiver still waits for a buffer
    if ($urandom_range(9) == 0) send_byte(8'($urandom));
    n = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    pick = $urandom_range(9);
    if (flaw == FL_OVERFLOW) cap = 16'($urandom_range(0, n));  // check byte will not fit
    else if (pick < 2) cap = 16'(n + 1);
    else if (pick < 3) cap = 16'($urandom_range(n + 1, 65535));
    else cap = 16'(n + 1 + $urandom_range(0, 8));
    offer_event(OP_GRANT, 8'($urandom), cap, 1'b1);
    if (flaw == FL_EMPTY) begin
      send_byte(r_flag);
      return;
    end
    sum = '0;
    for (int k = 0; k < n; k++) begin
      // lean toward values that need stuffing or sit at the extremes
      case ($urandom_range(9))
        0: v = r_flag;
        1: v = r_esc;
        2: v = $urandom_range(1) ? 8'h00 : 8'hFF;
        default: v = 8'($urandom);
      endcase
      sum ^= v;
      send_stuffed(v);
    end
    if (flaw == FL_CHECK) sum ^= 8'($urandom_range(1, 255));
    send_stuffed(sum);
    if (flaw != FL_CUT) send_byte(r_flag);
  endtask

  // one random slice of traffic: mostly frames, some noise, link events
  task automatic run_episode();
    int r;
    r = $urandom_range(99);
    if (!link_up) begin
      if (r < 30) send_byte(8'($urandom));
      else offer_event(OP_OPEN, 8'($urandom), 16'($urandom), 1'b1);
    end else if (r < 50) begin
      send_frame(FL_NONE);
    end else if (r < 66) begin
      send_frame(flaw_t'($urandom_range(1, 6)));
    end else if (r < 76) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (r < 81) begin
      offer_event(OP_GRANT, 8'($urandom), 16'($urandom), 1'b0);
    end else if (r < 84) begin
      offer_event(OP_OPEN, 8'($urandom), 16'($urandom), 1'b1);
    end else if (r < 87) begin
      offer_event(OP_CLOSE, 8'($urandom), 16'($urandom), 1'b1);
    end else if (r < 89) begin
      drain();
    end else begin
      case ($urandom_range(3))
        0: send_byte(r_flag);
        1: send_byte(r_esc);
        2: send_byte(8'h00);
        default: send_byte(8'hFF);
      endcase
    end
  endtask

  initial begin
    int goal;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset register values
    send_byte(FLAG_RST);                              // byte on a closed link
    offer_event(OP_GRANT, 8'hFF, 16'hFFFF, 1'b0);     // grant with no frame waiting
    offer_event(OP_OPEN, 8'h00, 16'h0000, 1'b1);
    offer_event(OP_OPEN, 8'hFF, 16'hFFFF, 1'b1);      // open while already open
    send_byte(FLAG_RST);
    send_byte(FLAG_RST);                              // flag while waiting for the address
    send_byte(ADDR_A_RST);
    send_byte(FLAG_RST);                              // unknown command that is a flag
    send_byte(ADDR_B_RST);
    send_byte(CMD_I_A);
    send_byte(ADDR_B_RST ^ CMD_I_A);                  // header ok, buffer needed
    send_byte(8'h55);                                 // byte while the buffer is missing
    offer_event(OP_GRANT, 8'h00, 16'h0000, 1'b1);
    send_byte(FLAG_RST);                              // empty payload is rejected
    send_byte(ADDR_A_RST);
    send_byte(CMD_I_B);
    send_byte(ADDR_A_RST ^ CMD_I_B);
    offer_event(OP_GRANT, 8'h00, 16'hFFFF, 1'b1);
    send_byte(ESCAPE_RST);
    send_byte(FLAG_RST ^ STUFF_XOR);                  // escaped flag value
    send_byte(8'hFF);
    send_byte(FLAG_RST ^ 8'hFF);                      // payload check byte
    send_byte(FLAG_RST);                              // good information frame
    send_byte(FLAG_RST);                              // byte right after a good frame
    offer_event(OP_CLOSE, 8'hFF, 16'h0000, 1'b1);

    // random part in register phases; each boundary drains the pipe first
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: set_link_regs(8'hFF, 8'h00, 8'h00, 8'hFF);  // second address equals the flag
          2: set_link_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
          3: set_link_regs(8'h00, 8'hFF, 8'hFF, 8'h80);
          default: set_link_regs(FLAG_RST, ESCAPE_RST, ADDR_A_RST, ADDR_B_RST);
        endcase
      end
      quiet = (p == 2);  // one phase runs with no idling on either side
      goal = accepted + PHASE_EVENTS;
      while (accepted < goal) run_episode();
    end
    quiet = 1'b0;

    drain();
    repeat (4) @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
